@@ rtl/dit_pkg.sv @@
package dit_pkg;

   // kind of an input word, carried in req_tuser
   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_DUMP = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   // commands broadcast to every cell
   typedef struct packed {
      logic add_en;     // an add word is taken this cycle
      logic rotate_en;  // dump moves the ring one place toward cell 0
      logic hit;        // some cell holds or touches the value
      logic merge;      // the touched cell bridges into its right neighbor
      logic full;       // every cell is occupied
   } cell_ctrl_type;

   // per-cell compare results sent back to the top
   typedef struct packed {
      logic below;       // interval ends more than one under the value
      logic first;       // first cell that is not below
      logic hit_here;    // this first cell holds or touches the value
      logic merge_here;  // grown interval reaches the right neighbor
   } cell_stat_type;

endpackage

@@ rtl/dit_cell.sv @@
module dit_cell
   import dit_pkg::*;
#(
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [VALUE_BITS-1:0] value,
   input  logic [VALUE_BITS-1:0] left_start,
   input  logic [VALUE_BITS-1:0] left_end,
   input  logic                  left_valid,
   input  logic                  left_below,
   input  logic [VALUE_BITS-1:0] right_start,
   input  logic [VALUE_BITS-1:0] right_end,
   input  logic                  right_valid,
   input  logic [VALUE_BITS-1:0] head_start,
   input  logic [VALUE_BITS-1:0] head_end,
   output logic [VALUE_BITS-1:0] start_out,
   output logic [VALUE_BITS-1:0] end_out,
   output logic                  valid_out,
   output cell_stat_type         stat
);

   localparam int WB = VALUE_BITS + 1;

   logic [VALUE_BITS-1:0] start_ff, start_in;
   logic [VALUE_BITS-1:0] end_ff, end_in;
   logic                  valid_ff, valid_in;

   logic [WB-1:0]         value_w;
   logic [WB-1:0]         value_p1;
   logic [WB-1:0]         end_p1;
   logic [VALUE_BITS-1:0] grow_start;
   logic [VALUE_BITS-1:0] grow_end;
   logic [WB-1:0]         grow_end_p1;

   // compares against the broadcast value, one bit wider so nothing wraps
   always_comb begin
      value_w     = {1'b0, value};
      value_p1    = value_w + WB'(1);
      end_p1      = {1'b0, end_ff} + WB'(1);
      grow_start  = (value < start_ff) ? value : start_ff;
      grow_end    = (value > end_ff) ? value : end_ff;
      grow_end_p1 = {1'b0, grow_end} + WB'(1);

      stat.below      = valid_ff && (end_p1 < value_w);
      stat.first      = !stat.below && left_below;
      stat.hit_here   = stat.first && valid_ff && ({1'b0, start_ff} <= value_p1);
      stat.merge_here = stat.hit_here && right_valid &&
                        ({1'b0, right_start} <= grow_end_p1);
   end

   // next contents: extend, merge-shift, insert-shift or rotate
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      valid_in = valid_ff;
      if (ctrl.add_en) begin
         if (ctrl.hit) begin
            if (stat.first) begin
               start_in = grow_start;
               end_in   = ctrl.merge ? right_end : grow_end;
            end else if (!stat.below && ctrl.merge) begin
               start_in = right_start;
               end_in   = right_end;
               valid_in = right_valid;
            end
         end else if (!ctrl.full) begin
            if (stat.first) begin
               start_in = value;
               end_in   = value;
               valid_in = 1'b1;
            end else if (!stat.below) begin
               start_in = left_start;
               end_in   = left_end;
               valid_in = left_valid;
            end
         end
      end else if (ctrl.rotate_en && valid_ff) begin
         start_in = right_valid ? right_start : head_start;
         end_in   = right_valid ? right_end : head_end;
      end
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // interval bounds
   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   assign start_out = start_ff;
   assign end_out   = end_ff;
   assign valid_out = valid_ff;

endmodule

@@ rtl/disjoint_interval_tracker_top.sv @@
// Sorted set of disjoint, non-adjacent intervals held in a row of MAX_INTERVALS
// cells, cell 0 holding the lowest. An add word (req_tuser = 0) brings a value
// in req_tdata; every cell compares it at once and the row extends, merges or
// opens a one-value interval, so adds are taken one per cycle while no dump
// is running, and give no result. A value that needs a new interval while all
// cells are full is dropped and sets the sticky overflow bit. A dump word
// (req_tuser = 1) streams every interval in ascending order, one per cycle
// while rsp_tready allows, by rotating the row through cell 0; the block
// takes no new word until the last result is loaded. An empty set dumps one
// result with table_empty set. rsp_tlast marks the final result of a dump.
module disjoint_interval_tracker_top
   import dit_pkg::*;
#(
   parameter int MAX_INTERVALS = 32,
   parameter int VALUE_BITS    = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // value
   input  logic [((VALUE_BITS+7)/8)*8-1:0]       req_tdata,
   // action
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // range_start, range_end
   output logic [((2*VALUE_BITS+7)/8)*8-1:0]     rsp_tdata,
   output logic                                  rsp_tlast,
   // table_empty, overflowed
   output logic [1:0]                            rsp_tuser
);

   localparam int OUT_DW = ((2*VALUE_BITS+7)/8)*8;
   localparam int CW     = $clog2(MAX_INTERVALS + 1);

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         remain_ff, remain_in;
   logic                  overflow_ff, overflow_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic [VALUE_BITS-1:0] rsp_end_ff, rsp_end_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic [VALUE_BITS-1:0] cell_start [MAX_INTERVALS];
   logic [VALUE_BITS-1:0] cell_end   [MAX_INTERVALS];
   logic [MAX_INTERVALS-1:0] cell_valid;
   cell_stat_type         cell_stat  [MAX_INTERVALS];
   logic [MAX_INTERVALS-1:0] hit_vec;
   logic [MAX_INTERVALS-1:0] merge_vec;

   cell_ctrl_type         ctrl;
   logic [VALUE_BITS-1:0] req_value;
   logic                  req_take;
   logic                  out_free;
   logic                  set_empty;

   assign req_value  = req_tdata[VALUE_BITS-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign set_empty  = (count_ff == CW'(0));

   // row of cells
   for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
      logic [VALUE_BITS-1:0] l_start, l_end, r_start, r_end;
      logic                  l_valid, l_below, r_valid;

      if (k == 0) begin : g_left_edge
         assign l_start = '0;
         assign l_end   = '0;
         assign l_valid = 1'b0;
         assign l_below = 1'b1;
      end else begin : g_left
         assign l_start = cell_start[k-1];
         assign l_end   = cell_end[k-1];
         assign l_valid = cell_valid[k-1];
         assign l_below = cell_stat[k-1].below;
      end

      if (k == MAX_INTERVALS - 1) begin : g_right_edge
         assign r_start = '0;
         assign r_end   = '0;
         assign r_valid = 1'b0;
      end else begin : g_right
         assign r_start = cell_start[k+1];
         assign r_end   = cell_end[k+1];
         assign r_valid = cell_valid[k+1];
      end

      dit_cell #(
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .value       (req_value),
         .left_start  (l_start),
         .left_end    (l_end),
         .left_valid  (l_valid),
         .left_below  (l_below),
         .right_start (r_start),
         .right_end   (r_end),
         .right_valid (r_valid),
         .head_start  (cell_start[0]),
         .head_end    (cell_end[0]),
         .start_out   (cell_start[k]),
         .end_out     (cell_end[k]),
         .valid_out   (cell_valid[k]),
         .stat        (cell_stat[k])
      );

      assign hit_vec[k]   = cell_stat[k].hit_here;
      assign merge_vec[k] = cell_stat[k].merge_here;
   end

   // broadcast commands
   always_comb begin
      ctrl.add_en    = req_take && (req_tuser == ACT_ADD);
      ctrl.rotate_en = (state_ff == ST_DUMP) && out_free && !set_empty;
      ctrl.hit       = |hit_vec;
      ctrl.merge     = |merge_vec;
      ctrl.full      = (count_ff == CW'(MAX_INTERVALS));
   end

   // count, overflow, dump sequencer and result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (ctrl.add_en) begin
         if (ctrl.hit) begin
            if (ctrl.merge) begin
               count_in = count_ff - CW'(1);
            end
         end else if (ctrl.full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_tuser == ACT_DUMP)) begin
               state_in  = ST_DUMP;
               remain_in = count_ff;
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = set_empty;
               rsp_ovf_in   = overflow_ff;
               rsp_start_in = set_empty ? '0 : cell_start[0];
               rsp_end_in   = set_empty ? '0 : cell_end[0];
               rsp_last_in  = set_empty || (remain_ff == CW'(1));
               remain_in    = remain_ff - CW'(1);
               if (set_empty || (remain_ff == CW'(1))) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DW'({rsp_end_ff, rsp_start_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_empty_ff};

`ifndef SYNTH
   // the number of occupied cells always equals the count
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("cell occupancy differs from interval count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_INTERVALS))
      else $error("interval count above capacity");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared without reset");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("empty result not marked last");
`endif

endmodule

@@ tb/sv/tb.sv @@
module tb
   import dit_pkg::*;
;

   localparam int SLOTS      = 32;
   localparam int VBITS      = 16;
   localparam int VMAX       = (1 << VBITS) - 1;
   localparam int CYCLE_CAP  = 1_200_000;
   localparam int RAND_WORDS = 300;

   // one expected dump word
   typedef struct packed {
      logic [VBITS-1:0] lo;
      logic [VBITS-1:0] hi;
      logic             last;
      logic             empty;
      logic             spill;
   } span_word_type;

   // sorted interval set kept alongside the block, plus the dump words still due
   class interval_ledger;
      bit [VBITS-1:0] lo_tab[SLOTS];
      bit [VBITS-1:0] hi_tab[SLOTS];
      int             used;
      bit             spilled;
      span_word_type  due_spans[$];
      int             faults;

      function void flag(string what);
         faults++;
         if (faults <= 10) begin
            $display("mismatch at %0t: %s", $realtime, what);
         end
      endfunction

      // grow, bridge or open an interval for one value
      function void insert_value(int v);
         int i;
         int k;
         i = 0;
         while (i < used && int'(hi_tab[i]) + 1 < v) i++;
         if (i < used && int'(lo_tab[i]) <= v + 1) begin
            if (v < int'(lo_tab[i])) lo_tab[i] = VBITS'(v);
            if (v > int'(hi_tab[i])) hi_tab[i] = VBITS'(v);
            // grown interval now touches its right neighbor
            if (i + 1 < used && int'(lo_tab[i+1]) <= int'(hi_tab[i]) + 1) begin
               hi_tab[i] = hi_tab[i+1];
               for (k = i + 1; k + 1 < used; k++) begin
                  lo_tab[k] = lo_tab[k+1];
                  hi_tab[k] = hi_tab[k+1];
               end
               used--;
            end
            return;
         end
         if (used >= SLOTS) begin
            spilled = 1'b1;
            return;
         end
         for (k = used; k > i; k--) begin
            lo_tab[k] = lo_tab[k-1];
            hi_tab[k] = hi_tab[k-1];
         end
         lo_tab[i] = VBITS'(v);
         hi_tab[i] = VBITS'(v);
         used++;
      endfunction

      // accepted input word
      function void note_word(logic act, logic [VBITS-1:0] val);
         span_word_type w;
         int k;
         if (act == ACT_ADD) begin
            insert_value(int'(val));
            return;
         end
         if (used == 0) begin
            w = '{lo: '0, hi: '0, last: 1'b1, empty: 1'b1, spill: spilled};
            due_spans = {due_spans, w};
            return;
         end
         for (k = 0; k < used; k++) begin
            w = '{lo: lo_tab[k], hi: hi_tab[k], last: (k + 1 == used),
                  empty: 1'b0, spill: spilled};
            due_spans = {due_spans, w};
         end
      endfunction

      // accepted result word
      function void check_word(logic [2*VBITS-1:0] data, logic last, logic [1:0] user);
         span_word_type w;
         if (due_spans.size() == 0) begin
            flag($sformatf("unexpected word data %h last %b user %b", data, last, user));
            return;
         end
         w = due_spans.pop_front();
         if (data[VBITS-1:0] !== w.lo)
            flag($sformatf("range_start exp %h got %h", w.lo, data[VBITS-1:0]));
         if (data[2*VBITS-1:VBITS] !== w.hi)
            flag($sformatf("range_end exp %h got %h", w.hi, data[2*VBITS-1:VBITS]));
         if (last !== w.last)
            flag($sformatf("last_range exp %b got %b", w.last, last));
         if (user[0] !== w.empty)
            flag($sformatf("table_empty exp %b got %b", w.empty, user[0]));
         if (user[1] !== w.spill)
            flag($sformatf("overflowed exp %b got %b", w.spill, user[1]));
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [VBITS-1:0] req_tdata  = '0;
   logic             req_tuser  = ACT_ADD;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [2*VBITS-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic [1:0]       rsp_tuser;

   interval_ledger   ledger = new();
   int               cycles = 0;
   int               hold_left = 0;
   bit               calm_send = 1'b0;
   int               win_base = 0;

   disjoint_interval_tracker_top #(
      .MAX_INTERVALS(SLOTS),
      .VALUE_BITS   (VBITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver stalls: mostly short, a few long, quiet stretches now and then
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (cycles[8] || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         hold_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(0, 2);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles >= CYCLE_CAP) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      if (calm_send) return 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 0;
         5, 6, 7:       return $urandom_range(1, 3);
         8:             return $urandom_range(1, 6);
         default:       return $urandom_range(10, 30);
      endcase
   endfunction

   // one input word, held until taken
   task automatic send_word(logic act, logic [VBITS-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.note_word(act, val);
   endtask

   // stop sending until every due word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ledger.due_spans.size() != 0);
   endtask

   // narrow window for dense merges, or wide and edge values
   function automatic logic [VBITS-1:0] pick_value(bit wide);
      if (wide) begin
         case ($urandom_range(0, 3))
            0, 1:    return VBITS'($urandom_range(0, VMAX));
            2:       return ($urandom_range(0, 1) != 0) ? VBITS'($urandom_range(0, 3))
                                                        : VBITS'($urandom_range(VMAX - 3, VMAX));
            default: return VBITS'(win_base + $urandom_range(0, 127));
         endcase
      end
      return VBITS'(win_base + $urandom_range(0, 127));
   endfunction

   initial begin
      logic             act;
      logic [VBITS-1:0] val;
      int               n;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty dump, range edges, inside, extend, bridge, insert
      calm_send = 1'b1;
      send_word(ACT_DUMP, 16'h0000);
      send_word(ACT_ADD, 16'h0000);
      send_word(ACT_ADD, 16'hFFFF);
      send_word(ACT_ADD, 16'hFFFF);
      send_word(ACT_ADD, 16'h0002);
      send_word(ACT_ADD, 16'h0001);
      send_word(ACT_ADD, 16'hFFFD);
      send_word(ACT_ADD, 16'hFFFE);
      send_word(ACT_DUMP, 16'h5A5A);
      send_word(ACT_ADD, 16'h0004);
      send_word(ACT_ADD, 16'h0005);
      send_word(ACT_ADD, 16'h0003);
      send_word(ACT_ADD, 16'h0007);
      send_word(ACT_ADD, 16'h8000);
      send_word(ACT_ADD, 16'h00C8);
      send_word(ACT_ADD, 16'h00C6);
      send_word(ACT_ADD, 16'h00C7);
      send_word(ACT_ADD, 16'h0000);
      send_word(ACT_ADD, 16'h7FFF);
      send_word(ACT_DUMP, 16'hFFFF);
      calm_send = 1'b0;

      // random: dense window, then wide values that fill the table, then dense again
      win_base = $urandom_range(0, VMAX - 127);
      for (n = 0; n < RAND_WORDS; n++) begin
         if (n % 40 == 0) calm_send = ($urandom_range(0, 2) == 0);
         if (n == 120) begin
            drain();
            win_base = $urandom_range(0, VMAX - 127);
         end
         act = ($urandom_range(0, 7) == 0) ? ACT_DUMP : ACT_ADD;
         val = pick_value(n >= 120 && n < 220);
         send_word(act, val);
      end
      send_word(ACT_DUMP, VBITS'($urandom_range(0, VMAX)));

      drain();
      repeat (40) @(posedge clock);
      if (ledger.faults == 0 && ledger.due_spans.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ disjoint_interval_tracker_top.f @@
rtl/dit_pkg.sv
rtl/dit_cell.sv
rtl/disjoint_interval_tracker_top.sv
tb/sv/tb.sv
